### design/scgl_pkg.sv
// ----------------------------------------------------------------------------
// scgl_pkg: shared types and constants of the capture ring
// Request and response layouts, command and status codes, defaults.
// ----------------------------------------------------------------------------
package scgl_pkg;

  localparam int CAPACITY_DEF    = 65536;
  localparam int GAP_ENTRIES_DEF = 64;
  localparam int COUNT_BITS_DEF  = 48;
  localparam int QUEUE_DEPTH     = 4;

  localparam int SAMPLE_W = 16;
  localparam int LOST_W   = 32;
  localparam int INDEX_W  = 48;
  localparam int START_W  = INDEX_W - 1;
  localparam int LEN_W    = 17;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_LOSS  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_READ  = 2'd3
  } scgl_cmd_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_PENDING     = 2'd1,
    ST_OVERWRITTEN = 2'd2
  } scgl_status_t;

  typedef struct packed {
    scgl_cmd_t                  cmd;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [LOST_W-1:0]          lost_count;
    logic signed [INDEX_W-1:0]  window_start;
    logic [LEN_W-1:0]           window_length;
  } scgl_req_t;

  typedef struct packed {
    scgl_status_t               status;
    logic                       gap_touched;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic [INDEX_W-1:0]         samples_total;
  } scgl_rsp_t;

  // classified request as it sits in the queue
  typedef struct packed {
    scgl_cmd_t           cmd;
    logic [SAMPLE_W-1:0] sample;
    logic [LOST_W-1:0]   lost;
    logic                neg;
    logic [START_W-1:0]  start;
    logic [INDEX_W-1:0]  fin;
  } scgl_op_t;

  typedef struct packed {
    logic clearing;
  } scgl_stat_t;

endpackage

### design/scgl_req_if.sv
// ----------------------------------------------------------------------------
// scgl_req_if: request channel
// Valid/ready handshake carrying one command request.
// ----------------------------------------------------------------------------
interface scgl_req_if
  import scgl_pkg::*;
();
  logic      valid;
  logic      ready;
  scgl_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/scgl_rsp_if.sv
// ----------------------------------------------------------------------------
// scgl_rsp_if: response channel
// Valid/ready handshake carrying one command response.
// ----------------------------------------------------------------------------
interface scgl_rsp_if
  import scgl_pkg::*;
();
  logic      valid;
  logic      ready;
  scgl_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### design/sample_capture_ring_with_gap_log_unit.sv
// ----------------------------------------------------------------------------
// sample_capture_ring_with_gap_log_unit: capture ring with gap log
// Ring store of samples by absolute index, loss log, window checks.
// ----------------------------------------------------------------------------
// channel  dir  payload     meaning
// req      in   scgl_req_t  command: write, report loss, check window, read
// rsp      out  scgl_rsp_t  one response per request
//
// The back end runs writes and loss reports back to back while responses
// drain; the queue registers each request before execution. A window check
// answers at once when the status is not ok; else it scans the gap log
// entries in use (gap log read one entry per cycle), then answers. A read
// then passes the states S_SREAD and S_SDATA for the ring RAM. CAPACITY
// must be a power of two; the block does not check it. The ring slot is
// the low bits of the count. After reset a clearing pass zeroes the ring;
// no request is taken until it ends. A 4-entry queue and a response
// register let either side stall on its own.
// ----------------------------------------------------------------------------
module sample_capture_ring_with_gap_log_unit
  import scgl_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int GAP_ENTRIES = GAP_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  scgl_req_if.sink   req,
  scgl_rsp_if.source rsp
);

  scgl_stat_t stat;
  logic       push_valid;
  logic       push_ready;
  scgl_op_t   push_op;
  logic       pop_valid;
  logic       pop_ready;
  scgl_op_t   pop_op;

  scgl_front u_front (
    .req        (req),
    .stat       (stat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  scgl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  scgl_back #(
    .CAPACITY    (CAPACITY),
    .GAP_ENTRIES (GAP_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_op    (pop_op),
    .stat      (stat),
    .rsp       (rsp)
  );

endmodule

### design/scgl_ram.sv
// ----------------------------------------------------------------------------
// scgl_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scgl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/scgl_queue.sv
// ----------------------------------------------------------------------------
// scgl_queue: short request queue between front and back
// Small register FIFO of classified requests.
// ----------------------------------------------------------------------------
module scgl_queue
  import scgl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push_valid,
  output logic     push_ready,
  input  scgl_op_t push_op,
  output logic     pop_valid,
  input  logic     pop_ready,
  output scgl_op_t pop_op
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  scgl_op_t            entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                push;
  logic                pop;

  assign push_ready = (fill != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_op     = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### design/scgl_front.sv
// ----------------------------------------------------------------------------
// scgl_front: request intake and classification
// Splits the window start, forms the window end, feeds the queue.
// ----------------------------------------------------------------------------
module scgl_front
  import scgl_pkg::*;
(
  scgl_req_if.sink  req,
  input  scgl_stat_t stat,
  output logic       push_valid,
  input  logic       push_ready,
  output scgl_op_t   push_op
);

  logic [START_W-1:0] start;
  logic [INDEX_W-1:0] span;

  assign start = req.data.window_start[START_W-1:0];
  assign span  = (req.data.cmd == CMD_READ) ? INDEX_W'(1)
                                            : INDEX_W'(req.data.window_length);

  always_comb begin
    push_op.cmd    = req.data.cmd;
    push_op.sample = req.data.sample_in;
    push_op.lost   = req.data.lost_count;
    push_op.neg    = req.data.window_start[INDEX_W-1];
    push_op.start  = start;
    push_op.fin    = INDEX_W'(start) + span;
  end

  assign push_valid = req.valid && !stat.clearing;
  assign req.ready  = push_ready && !stat.clearing;

endmodule

### design/scgl_back.sv
// ----------------------------------------------------------------------------
// scgl_back: command execution
// Sample ring, gap log, window check with gap scan.
// ----------------------------------------------------------------------------
module scgl_back
  import scgl_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int GAP_ENTRIES = GAP_ENTRIES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  scgl_op_t   pop_op,
  output scgl_stat_t stat,
  scgl_rsp_if.source rsp
);

  localparam int SLOT_BITS = $clog2(CAPACITY);
  localparam int GA_BITS   = (GAP_ENTRIES > 1) ? $clog2(GAP_ENTRIES) : 1;
  localparam int USED_BITS = $clog2(GAP_ENTRIES + 1);
  localparam int CW        = (COUNT_BITS > INDEX_W + 1) ? COUNT_BITS : INDEX_W + 1;
  localparam int GAP_W     = 2 * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EVAL  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_SREAD = 6'b010000,
    S_SDATA = 6'b100000
  } state_t;

  state_t               state;
  logic [SLOT_BITS-1:0] clr_addr;
  logic [COUNT_BITS-1:0] count;
  logic [USED_BITS-1:0] gap_used;
  logic [GA_BITS-1:0]   gap_oldest;
  scgl_op_t             cur;
  logic                 touched;
  logic [USED_BITS-1:0] scan_idx;
  logic                 scan_pend;
  logic                 rsp_valid;
  scgl_rsp_t            rsp_data;

  logic                  pop;
  logic                  out_free;
  logic                  rsp_load;
  logic [CW-1:0]         count_ext;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS:0]   loss_sum;
  logic [COUNT_BITS-1:0] loss_end;
  logic                  gap_full;
  logic                  gap_we;
  logic [GA_BITS-1:0]    gap_waddr;
  logic [GAP_W-1:0]      gap_rdata;
  logic [CW-1:0]         fin_ext;
  logic [CW-1:0]         start_ext;
  logic [CW-1:0]         behind;
  scgl_status_t          eval_status;
  logic [CW-1:0]         g_begin;
  logic [CW-1:0]         g_end;
  logic                  gap_hit;
  logic                  issuing;
  logic                  s_we;
  logic [SLOT_BITS-1:0]  s_waddr;
  logic [SAMPLE_W-1:0]   s_wdata;
  logic [SAMPLE_W-1:0]   s_rdata;

  assign out_free  = !rsp_valid || rsp.ready;
  assign pop_ready = (state == S_IDLE) && out_free;
  assign pop       = pop_valid && pop_ready;
  assign stat.clearing = (state == S_CLEAR);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  assign count_ext = CW'(count);
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;
  assign loss_sum  = {1'b0, count} + (COUNT_BITS + 1)'(pop_op.lost);
  assign loss_end  = (loss_sum > {1'b0, COUNT_MAX}) ? COUNT_MAX
                                                    : loss_sum[COUNT_BITS-1:0];

  assign gap_full  = (gap_used == USED_BITS'(GAP_ENTRIES));
  assign gap_we    = pop && (pop_op.cmd == CMD_LOSS) && (pop_op.lost != '0);
  assign gap_waddr = gap_full ? gap_oldest : gap_used[GA_BITS-1:0];

  assign fin_ext   = CW'(cur.fin);
  assign start_ext = CW'(cur.start);
  assign behind    = count_ext - start_ext;

  always_comb begin
    if (cur.neg) begin
      eval_status = ST_OVERWRITTEN;
    end else if (fin_ext > count_ext) begin
      eval_status = ST_PENDING;
    end else if (behind > CW'(CAPACITY)) begin
      eval_status = ST_OVERWRITTEN;
    end else begin
      eval_status = ST_OK;
    end
  end

  assign g_begin = CW'(gap_rdata[GAP_W-1:COUNT_BITS]);
  assign g_end   = CW'(gap_rdata[COUNT_BITS-1:0]);
  assign gap_hit = (g_begin < fin_ext) && (g_end > start_ext);
  assign issuing = (scan_idx < gap_used);

  assign rsp_load = (pop && ((pop_op.cmd == CMD_WRITE) || (pop_op.cmd == CMD_LOSS)))
                 || ((state == S_EVAL) && (eval_status != ST_OK))
                 || ((state == S_SCAN) && !issuing && !scan_pend && (cur.cmd != CMD_READ))
                 || (state == S_SDATA);

  assign s_we    = (state == S_CLEAR) || (pop && (pop_op.cmd == CMD_WRITE));
  assign s_waddr = (state == S_CLEAR) ? clr_addr : count[SLOT_BITS-1:0];
  assign s_wdata = (state == S_CLEAR) ? '0 : pop_op.sample;

  scgl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (CAPACITY),
    .AW    (SLOT_BITS)
  ) u_sample_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (cur.start[SLOT_BITS-1:0]),
    .rdata (s_rdata)
  );

  scgl_ram #(
    .WIDTH (GAP_W),
    .DEPTH (GAP_ENTRIES),
    .AW    (GA_BITS)
  ) u_gap_ram (
    .clk   (clk),
    .we    (gap_we),
    .waddr (gap_waddr),
    .wdata ({count, loss_end}),
    .raddr (scan_idx[GA_BITS-1:0]),
    .rdata (gap_rdata)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      count      <= '0;
      gap_used   <= '0;
      gap_oldest <= '0;
      touched    <= 1'b0;
      scan_idx   <= '0;
      scan_pend  <= 1'b0;
      rsp_data   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == SLOT_BITS'(CAPACITY - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            case (pop_op.cmd)
              CMD_WRITE: begin
                count    <= count_inc;
                rsp_data <= '{ST_OK, 1'b0, '0, INDEX_W'(CW'(count_inc))};
              end
              CMD_LOSS: begin
                if (pop_op.lost != '0) begin
                  count <= loss_end;
                  if (gap_full) begin
                    gap_oldest <= (gap_oldest == GA_BITS'(GAP_ENTRIES - 1))
                                ? '0 : gap_oldest + 1'b1;
                  end else begin
                    gap_used <= gap_used + 1'b1;
                  end
                  rsp_data <= '{ST_OK, 1'b0, '0, INDEX_W'(CW'(loss_end))};
                end else begin
                  rsp_data <= '{ST_OK, 1'b0, '0, count_ext[INDEX_W-1:0]};
                end
              end
              default: begin
                state <= S_EVAL;
              end
            endcase
          end
        end
        S_EVAL: begin
          if (eval_status != ST_OK) begin
            rsp_data <= '{eval_status, 1'b0, '0, count_ext[INDEX_W-1:0]};
            state    <= S_IDLE;
          end else begin
            touched   <= 1'b0;
            scan_idx  <= '0;
            scan_pend <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            scan_idx <= scan_idx + 1'b1;
          end
          scan_pend <= issuing;
          if (scan_pend && gap_hit) begin
            touched <= 1'b1;
          end
          if (!issuing && !scan_pend) begin
            if (cur.cmd == CMD_READ) begin
              state <= S_SREAD;
            end else begin
              rsp_data <= '{ST_OK, touched, '0, count_ext[INDEX_W-1:0]};
              state    <= S_IDLE;
            end
          end
        end
        S_SREAD: begin
          state <= S_SDATA;
        end
        S_SDATA: begin
          rsp_data <= '{ST_OK, touched, s_rdata, count_ext[INDEX_W-1:0]};
          state    <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
